@@ sv/hslh_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hslh_pkg
// shared constants, request codes and control structs of the hsl histogram
// ---------------------------------------------------------------------------
package hslh_pkg;

    localparam int BIN_COUNT  = 256;
    localparam int COUNT_BITS = 32;
    localparam int PIX_BITS   = 8;
    localparam int FIELD_BITS = 32;
    localparam int IDX_BITS   = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int SUM_BITS   = COUNT_BITS + PIX_BITS;
    localparam int QUO_BITS   = PIX_BITS;
    localparam int STEP_BITS  = $clog2(QUO_BITS);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [1:0] req_t;

    localparam req_t REQ_ADD   = 2'd0;
    localparam req_t REQ_CLEAR = 2'd1;
    localparam req_t REQ_READ  = 2'd2;
    localparam req_t REQ_MEAN  = 2'd3;

    // per-bank strobes for one cycle
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } bank_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic in_range(input logic [PIX_BITS-1:0] v);
        logic [PIX_BITS:0] wide;
        wide = {1'b0, v};
        return wide < (PIX_BITS + 1)'(BIN_COUNT);
    endfunction

endpackage

@@ sv/hslh_bank.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hslh_bank
// one histogram: bin memory with valid bits, write forwarding, saturating bump
// ---------------------------------------------------------------------------
module hslh_bank
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  hslh_pkg::bank_ctl_t                 ctl,
    input  logic [hslh_pkg::IDX_BITS-1:0]       rd_addr,
    output logic [hslh_pkg::COUNT_BITS-1:0]     count
);

    logic [hslh_pkg::COUNT_BITS-1:0] mem [0:hslh_pkg::BIN_COUNT-1];
    logic [hslh_pkg::BIN_COUNT-1:0]  vld_reg;

    logic [hslh_pkg::COUNT_BITS-1:0] rd_data_reg;
    logic [hslh_pkg::IDX_BITS-1:0]   addr_reg;
    logic                            vbit_reg;
    logic [hslh_pkg::IDX_BITS-1:0]   fwd_addr_reg;
    logic [hslh_pkg::COUNT_BITS-1:0] fwd_data_reg;
    logic                            fwd_en_reg;
    logic                            stale_reg;
    logic [hslh_pkg::COUNT_BITS-1:0] inc_next;

    // stale: the sampled entry predates a clear that has since landed
    always_comb
    begin
        if (stale_reg)
        begin
            count = '0;
        end
        else if (fwd_en_reg && (fwd_addr_reg == addr_reg))
        begin
            count = fwd_data_reg;
        end
        else if (vbit_reg)
        begin
            count = rd_data_reg;
        end
        else
        begin
            count = '0;
        end
    end

    assign inc_next = (count == hslh_pkg::COUNT_MAX) ? count : count + 1'b1;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr_reg] <= inc_next;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            addr_reg    <= rd_addr;
        end
        if (ctl.wr_en)
        begin
            fwd_addr_reg <= addr_reg;
            fwd_data_reg <= inc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            vbit_reg   <= 1'b0;
            fwd_en_reg <= 1'b0;
            stale_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.clr)
            begin
                vld_reg    <= '0;
                fwd_en_reg <= 1'b0;
            end
            else if (ctl.wr_en)
            begin
                vld_reg[addr_reg] <= 1'b1;
                fwd_en_reg        <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                vbit_reg <= vld_reg[rd_addr];
            end
            if (ctl.clr)
            begin
                stale_reg <= 1'b1;
            end
            else if (ctl.rd_en)
            begin
                stale_reg <= 1'b0;
            end
        end
    end

endmodule

@@ sv/hslh_mean_div.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hslh_mean_div
// restoring divider, one quotient bit per cycle, sum over total
// ---------------------------------------------------------------------------
module hslh_mean_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                ack,
    input  logic [hslh_pkg::SUM_BITS-1:0]       sum,
    input  logic [hslh_pkg::COUNT_BITS-1:0]     total,
    output hslh_pkg::div_stat_t                 stat,
    output logic [hslh_pkg::QUO_BITS-1:0]       quotient
);

    typedef enum logic [2:0]
    {
        DIV_IDLE = 3'b001,
        DIV_RUN  = 3'b010,
        DIV_DONE = 3'b100
    } div_state_t;

    div_state_t                       state_reg;
    div_state_t                       state_next;
    logic [hslh_pkg::SUM_BITS-1:0]    rem_reg;
    logic [hslh_pkg::SUM_BITS-1:0]    dsh_reg;
    logic [hslh_pkg::QUO_BITS-1:0]    quo_reg;
    logic [hslh_pkg::STEP_BITS-1:0]   step_reg;
    logic                             ge;

    assign ge       = rem_reg >= dsh_reg;
    assign quotient = quo_reg;
    assign stat.busy = (state_reg != DIV_IDLE);
    assign stat.done = (state_reg == DIV_DONE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    state_next = (total == '0) ? DIV_DONE : DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (step_reg == '0)
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                if (ack)
                begin
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // quotient fits in QUO_BITS since every pixel adds less than 2^QUO_BITS
    always_ff @(posedge clk)
    begin
        if ((state_reg == DIV_IDLE) && start)
        begin
            rem_reg  <= sum;
            dsh_reg  <= hslh_pkg::SUM_BITS'(total) << (hslh_pkg::QUO_BITS - 1);
            quo_reg  <= '0;
            step_reg <= hslh_pkg::STEP_BITS'(hslh_pkg::QUO_BITS - 1);
        end
        else if (state_reg == DIV_RUN)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg  <= {quo_reg[hslh_pkg::QUO_BITS-2:0], ge};
            dsh_reg  <= dsh_reg >> 1;
            step_reg <= step_reg - 1'b1;
        end
    end

endmodule

@@ sv/hsl_histogram_with_mean_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hsl_histogram_with_mean_core
// hue, saturation and lightness histograms with a running lightness mean
// ---------------------------------------------------------------------------
// add and clear beats take one per cycle while the divider is idle; bins are read
// at accept, bumped and written back the next cycle, with forwarding for repeated bins
// read beat: bin sample, then output register; one read per cycle unless m_axis stalls
// mean beat: 8-step divider (skipped when empty), quotient then registered on m_axis;
// input stalls until the quotient enters the output register
// reset is asynchronous; bin valid bits clear at once, no sweep over the memories
// ---------------------------------------------------------------------------
module hsl_histogram_with_mean_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [31:0]   s_axis_tdata,   // hue, saturation, lightness, bin_index
    input  logic [1:0]    s_axis_tuser,   // req_type
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata    // hue_count, saturation_count,
                                          // lightness_count, mean_value
);

    logic [hslh_pkg::PIX_BITS-1:0] in_hue;
    logic [hslh_pkg::PIX_BITS-1:0] in_sat;
    logic [hslh_pkg::PIX_BITS-1:0] in_lit;
    logic [hslh_pkg::PIX_BITS-1:0] in_bin;
    hslh_pkg::req_t                in_req;
    logic                          accept;

    logic                          s1_valid_reg;
    hslh_pkg::req_t                s1_req_reg;
    logic                          s1_hue_ok_reg;
    logic                          s1_sat_ok_reg;
    logic                          s1_lit_ok_reg;
    logic                          s1_bin_ok_reg;
    logic [hslh_pkg::PIX_BITS-1:0] s1_lit_reg;
    logic                          s1_done;

    logic [hslh_pkg::SUM_BITS-1:0]   sum_reg;
    logic [hslh_pkg::COUNT_BITS-1:0] total_reg;
    logic                            lit_take;

    hslh_pkg::bank_ctl_t             hue_ctl;
    hslh_pkg::bank_ctl_t             sat_ctl;
    hslh_pkg::bank_ctl_t             lit_ctl;
    logic [hslh_pkg::IDX_BITS-1:0]   hue_addr;
    logic [hslh_pkg::IDX_BITS-1:0]   sat_addr;
    logic [hslh_pkg::IDX_BITS-1:0]   lit_addr;
    logic [hslh_pkg::COUNT_BITS-1:0] hue_cnt;
    logic [hslh_pkg::COUNT_BITS-1:0] sat_cnt;
    logic [hslh_pkg::COUNT_BITS-1:0] lit_cnt;

    hslh_pkg::div_stat_t             div_stat;
    logic [hslh_pkg::QUO_BITS-1:0]   div_quo;
    logic                            div_start;
    logic                            div_ack;

    logic                              out_valid_reg;
    logic [hslh_pkg::FIELD_BITS-1:0]   out_hue_reg;
    logic [hslh_pkg::FIELD_BITS-1:0]   out_sat_reg;
    logic [hslh_pkg::FIELD_BITS-1:0]   out_lit_reg;
    logic [hslh_pkg::PIX_BITS-1:0]     out_mean_reg;
    logic                              out_free;
    logic                              rd_load;

    logic is_add;
    logic is_clr;
    logic is_rd;

    assign in_hue = s_axis_tdata[7:0];
    assign in_sat = s_axis_tdata[15:8];
    assign in_lit = s_axis_tdata[23:16];
    assign in_bin = s_axis_tdata[31:24];
    assign in_req = s_axis_tuser;

    assign out_free = !out_valid_reg || m_axis_tready;

    assign is_add = s1_valid_reg && (s1_req_reg == hslh_pkg::REQ_ADD);
    assign is_clr = s1_valid_reg && (s1_req_reg == hslh_pkg::REQ_CLEAR);
    assign is_rd  = s1_valid_reg && (s1_req_reg == hslh_pkg::REQ_READ);

    always_comb
    begin
        case (s1_req_reg)
            hslh_pkg::REQ_ADD:   s1_done = s1_valid_reg;
            hslh_pkg::REQ_CLEAR: s1_done = s1_valid_reg;
            hslh_pkg::REQ_READ:  s1_done = s1_valid_reg && out_free;
            hslh_pkg::REQ_MEAN:  s1_done = s1_valid_reg && !div_stat.busy;
            default:             s1_done = s1_valid_reg;
        endcase
    end

    // a mean beat holds the input until its quotient enters the output register
    assign s_axis_tready = !div_stat.busy &&
                           (!s1_valid_reg ||
                            (s1_done && (s1_req_reg != hslh_pkg::REQ_MEAN)));
    assign accept = s_axis_tvalid && s_axis_tready;

    assign rd_load   = is_rd && out_free;
    assign div_start = s1_valid_reg && (s1_req_reg == hslh_pkg::REQ_MEAN) && s1_done;
    assign div_ack   = div_stat.done && out_free;

    // total saturation also freezes the lightness bin and the sum
    assign lit_take = is_add && s1_lit_ok_reg && (total_reg != hslh_pkg::COUNT_MAX);

    assign hue_addr = (in_req == hslh_pkg::REQ_READ) ? in_bin[hslh_pkg::IDX_BITS-1:0]
                                                     : in_hue[hslh_pkg::IDX_BITS-1:0];
    assign sat_addr = (in_req == hslh_pkg::REQ_READ) ? in_bin[hslh_pkg::IDX_BITS-1:0]
                                                     : in_sat[hslh_pkg::IDX_BITS-1:0];
    assign lit_addr = (in_req == hslh_pkg::REQ_READ) ? in_bin[hslh_pkg::IDX_BITS-1:0]
                                                     : in_lit[hslh_pkg::IDX_BITS-1:0];

    always_comb
    begin
        hue_ctl.rd_en = accept;
        hue_ctl.wr_en = is_add && s1_hue_ok_reg;
        hue_ctl.clr   = is_clr;
        sat_ctl.rd_en = accept;
        sat_ctl.wr_en = is_add && s1_sat_ok_reg;
        sat_ctl.clr   = is_clr;
        lit_ctl.rd_en = accept;
        lit_ctl.wr_en = lit_take;
        lit_ctl.clr   = is_clr;
    end

    hslh_bank u_hue_bank
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (hue_ctl),
        .rd_addr (hue_addr),
        .count   (hue_cnt)
    );

    hslh_bank u_sat_bank
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (sat_ctl),
        .rd_addr (sat_addr),
        .count   (sat_cnt)
    );

    hslh_bank u_lit_bank
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (lit_ctl),
        .rd_addr (lit_addr),
        .count   (lit_cnt)
    );

    hslh_mean_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .ack      (div_ack),
        .sum      (sum_reg),
        .total    (total_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg    <= in_req;
            s1_hue_ok_reg <= hslh_pkg::in_range(in_hue);
            s1_sat_ok_reg <= hslh_pkg::in_range(in_sat);
            s1_lit_ok_reg <= hslh_pkg::in_range(in_lit);
            s1_bin_ok_reg <= hslh_pkg::in_range(in_bin);
            s1_lit_reg    <= in_lit;
        end
        if (div_ack)
        begin
            out_hue_reg  <= '0;
            out_sat_reg  <= '0;
            out_lit_reg  <= '0;
            out_mean_reg <= div_quo;
        end
        else if (rd_load)
        begin
            out_hue_reg  <= s1_bin_ok_reg ? hslh_pkg::FIELD_BITS'(hue_cnt) : '0;
            out_sat_reg  <= s1_bin_ok_reg ? hslh_pkg::FIELD_BITS'(sat_cnt) : '0;
            out_lit_reg  <= s1_bin_ok_reg ? hslh_pkg::FIELD_BITS'(lit_cnt) : '0;
            out_mean_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            sum_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (is_clr)
            begin
                sum_reg   <= '0;
                total_reg <= '0;
            end
            else if (lit_take)
            begin
                sum_reg   <= sum_reg + hslh_pkg::SUM_BITS'(s1_lit_reg);
                total_reg <= total_reg + 1'b1;
            end
            if (div_ack || rd_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_mean_reg, out_lit_reg, out_sat_reg, out_hue_reg};

endmodule

@@ sv/hslh_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hslh_checker
// port-level checks of the hsl histogram core, bound to the top level
// ---------------------------------------------------------------------------
module hslh_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic [31:0]   s_axis_tdata,
    input logic [1:0]    s_axis_tuser,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [103:0]  m_axis_tdata
);

    logic in_beat;

    assign in_beat = s_axis_tvalid && s_axis_tready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // a mean result carries no counts
    a_mean_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[103:96] != 8'd0) |-> (m_axis_tdata[95:0] == 96'd0))
        else $error("mean result with nonzero counts");

    // a mean beat blocks the input while it is divided
    a_mean_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && (s_axis_tuser == hslh_pkg::REQ_MEAN) |=> !s_axis_tready)
        else $error("input taken behind a mean beat");

    a_idle_data: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |-> !$isunknown({s_axis_tuser, s_axis_tdata}))
        else $error("unknown input data");

endmodule

bind hsl_histogram_with_mean_core hslh_checker u_hslh_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/tb_hsl_histogram_with_mean_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_hsl_histogram_with_mean_core
// drives pixel, clear, read and mean beats into the hsl histogram core and
// checks every read and mean beat against a software copy of the three
// histograms and the running lightness sum, under several idle/stall mixes
// ---------------------------------------------------------------------------
module tb_hsl_histogram_with_mean_core;

    typedef struct {
        logic [hslh_pkg::FIELD_BITS-1:0] hue_count;
        logic [hslh_pkg::FIELD_BITS-1:0] saturation_count;
        logic [hslh_pkg::FIELD_BITS-1:0] lightness_count;
        logic [hslh_pkg::PIX_BITS-1:0]   mean_value;
    } readout_t;

    logic          clk           = 1'b0;
    logic          rst_n         = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [31:0]   s_axis_tdata  = '0;   // hue, saturation, lightness, bin_index
    logic [1:0]    s_axis_tuser  = '0;   // req_type
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [103:0]  m_axis_tdata;         // hue_count, saturation_count,
                                         // lightness_count, mean_value

    logic [hslh_pkg::COUNT_BITS-1:0] hue_tally   [hslh_pkg::BIN_COUNT];
    logic [hslh_pkg::COUNT_BITS-1:0] sat_tally   [hslh_pkg::BIN_COUNT];
    logic [hslh_pkg::COUNT_BITS-1:0] light_tally [hslh_pkg::BIN_COUNT];
    logic [hslh_pkg::SUM_BITS-1:0]   light_sum;
    logic [hslh_pkg::COUNT_BITS-1:0] pixel_count;

    readout_t expected_readouts[$];
    int       error_count   = 0;
    int       src_idle_pct  = 0;
    int       rcv_stall_pct = 0;

    hsl_histogram_with_mean_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end

    function automatic void clear_tallies();
        for (int i = 0; i < hslh_pkg::BIN_COUNT; i++)
        begin
            hue_tally[i]   = '0;
            sat_tally[i]   = '0;
            light_tally[i] = '0;
        end
        light_sum   = '0;
        pixel_count = '0;
    endfunction

    function automatic logic [hslh_pkg::COUNT_BITS-1:0] bump_count(
        input logic [hslh_pkg::COUNT_BITS-1:0] c);
        return (c == hslh_pkg::COUNT_MAX) ? c : c + 1'b1;
    endfunction

    // update the histogram copy for one accepted beat, queue a readout if one is due
    function automatic void track_histogram(input hslh_pkg::req_t req,
                                            input logic [7:0] h,
                                            input logic [7:0] s, input logic [7:0] l,
                                            input logic [7:0] b);
        readout_t r;
        r.hue_count        = '0;
        r.saturation_count = '0;
        r.lightness_count  = '0;
        r.mean_value       = '0;
        case (req)
            hslh_pkg::REQ_ADD:
            begin
                if (int'(h) < hslh_pkg::BIN_COUNT)
                    hue_tally[h] = bump_count(hue_tally[h]);
                if (int'(s) < hslh_pkg::BIN_COUNT)
                    sat_tally[s] = bump_count(sat_tally[s]);
                // lightness stops counting once the total is pinned
                if (int'(l) < hslh_pkg::BIN_COUNT && pixel_count != hslh_pkg::COUNT_MAX)
                begin
                    light_tally[l] = light_tally[l] + 1'b1;
                    pixel_count    = pixel_count + 1'b1;
                    light_sum      = light_sum + hslh_pkg::SUM_BITS'(l);
                end
            end
            hslh_pkg::REQ_CLEAR:
                clear_tallies();
            hslh_pkg::REQ_READ:
            begin
                if (int'(b) < hslh_pkg::BIN_COUNT)
                begin
                    r.hue_count        = hslh_pkg::FIELD_BITS'(hue_tally[b]);
                    r.saturation_count = hslh_pkg::FIELD_BITS'(sat_tally[b]);
                    r.lightness_count  = hslh_pkg::FIELD_BITS'(light_tally[b]);
                end
                expected_readouts.push_back(r);
            end
            hslh_pkg::REQ_MEAN:
            begin
                if (pixel_count != '0)
                    r.mean_value = hslh_pkg::PIX_BITS'(light_sum / pixel_count);
                expected_readouts.push_back(r);
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk)
    begin : check_readout
        readout_t want;
        readout_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.hue_count        = m_axis_tdata[31:0];
            got.saturation_count = m_axis_tdata[63:32];
            got.lightness_count  = m_axis_tdata[95:64];
            got.mean_value       = m_axis_tdata[103:96];
            if (expected_readouts.size() == 0)
            begin
                $error("unexpected result beat: tdata %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = expected_readouts.pop_front();
                if (got.hue_count !== want.hue_count)
                begin
                    $error("hue_count: expected %0d, actual %0d",
                           want.hue_count, got.hue_count);
                    error_count++;
                end
                if (got.saturation_count !== want.saturation_count)
                begin
                    $error("saturation_count: expected %0d, actual %0d",
                           want.saturation_count, got.saturation_count);
                    error_count++;
                end
                if (got.lightness_count !== want.lightness_count)
                begin
                    $error("lightness_count: expected %0d, actual %0d",
                           want.lightness_count, got.lightness_count);
                    error_count++;
                end
                if (got.mean_value !== want.mean_value)
                begin
                    $error("mean_value: expected %0d, actual %0d",
                           want.mean_value, got.mean_value);
                    error_count++;
                end
            end
        end
    end

    // entered just after a rising edge, returns just after the accepting edge
    task automatic send_beat(input hslh_pkg::req_t req, input logic [7:0] h,
                             input logic [7:0] s,
                             input logic [7:0] l, input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, l, s, h};
        s_axis_tuser  <= req;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        track_histogram(req, h, s, l, b);
    endtask

    task automatic test_empty_histogram();
        send_beat(hslh_pkg::REQ_MEAN, 8'h00, 8'h00, 8'h00, 8'h00);
        send_beat(hslh_pkg::REQ_READ, 8'hff, 8'hff, 8'hff, 8'h00);
        send_beat(hslh_pkg::REQ_READ, 8'h00, 8'h00, 8'h00, 8'hff);
    endtask

    task automatic test_field_extremes();
        send_beat(hslh_pkg::REQ_ADD, 8'h00, 8'h00, 8'h00, 8'hff);
        // same bins back to back exercise the bump forwarding path
        send_beat(hslh_pkg::REQ_ADD, 8'hff, 8'hff, 8'hff, 8'h00);
        send_beat(hslh_pkg::REQ_ADD, 8'hff, 8'hff, 8'hff, 8'h00);
        send_beat(hslh_pkg::REQ_ADD, 8'haa, 8'h55, 8'h80, 8'h5a);
        send_beat(hslh_pkg::REQ_READ, 8'h00, 8'h00, 8'h00, 8'h00);
        send_beat(hslh_pkg::REQ_READ, 8'h00, 8'h00, 8'h00, 8'hff);
        send_beat(hslh_pkg::REQ_READ, 8'h00, 8'h00, 8'h00, 8'haa);
        send_beat(hslh_pkg::REQ_READ, 8'h00, 8'h00, 8'h00, 8'h55);
        send_beat(hslh_pkg::REQ_READ, 8'h00, 8'h00, 8'h00, 8'h80);
        send_beat(hslh_pkg::REQ_MEAN, 8'hff, 8'hff, 8'hff, 8'hff);
    endtask

    task automatic test_clear();
        send_beat(hslh_pkg::REQ_CLEAR, 8'h12, 8'h34, 8'h56, 8'h78);
        send_beat(hslh_pkg::REQ_READ, 8'h00, 8'h00, 8'h00, 8'hff);
        send_beat(hslh_pkg::REQ_MEAN, 8'h00, 8'h00, 8'h00, 8'h00);
        send_beat(hslh_pkg::REQ_ADD, 8'h01, 8'h02, 8'h03, 8'h00);
        send_beat(hslh_pkg::REQ_READ, 8'h00, 8'h00, 8'h00, 8'h03);
        send_beat(hslh_pkg::REQ_MEAN, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_mean_truncation();
        send_beat(hslh_pkg::REQ_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
        send_beat(hslh_pkg::REQ_ADD, 8'h10, 8'h20, 8'h01, 8'h00);
        send_beat(hslh_pkg::REQ_ADD, 8'h10, 8'h20, 8'h02, 8'h00);
        send_beat(hslh_pkg::REQ_MEAN, 8'h00, 8'h00, 8'h00, 8'h00);
        send_beat(hslh_pkg::REQ_ADD, 8'h10, 8'h20, 8'hfe, 8'h00);
        send_beat(hslh_pkg::REQ_MEAN, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    // pixel streams with a hot window so reads hit bins with real counts
    task automatic test_random_traffic(input int count, input int src_idle,
                                       input int rcv_stall);
        logic [7:0] hot;
        int         roll;
        src_idle_pct  = src_idle;
        rcv_stall_pct = rcv_stall;
        hot = 8'($urandom_range(255));
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
                send_beat(hslh_pkg::REQ_ADD,
                          $urandom_range(1) ? 8'(hot + $urandom_range(7)) : 8'($urandom),
                          $urandom_range(1) ? 8'(hot + $urandom_range(7)) : 8'($urandom),
                          $urandom_range(1) ? 8'(hot + $urandom_range(7)) : 8'($urandom),
                          8'($urandom));
            else if (roll < 90)
                send_beat(hslh_pkg::REQ_READ, 8'($urandom), 8'($urandom), 8'($urandom),
                          $urandom_range(3) != 0 ? 8'(hot + $urandom_range(7))
                                                 : 8'($urandom));
            else if (roll < 98)
                send_beat(hslh_pkg::REQ_MEAN, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom));
            else
            begin
                send_beat(hslh_pkg::REQ_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom));
                hot = 8'($urandom_range(255));
            end
        end
    endtask

    initial
    begin
        clear_tallies();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_histogram();
        test_field_extremes();
        test_clear();
        test_mean_truncation();
        test_random_traffic(380, 0, 0);
        test_random_traffic(380, 75, 0);
        test_random_traffic(380, 0, 75);
        test_random_traffic(380, 22, 22);

        s_axis_tvalid <= 1'b0;
        while (expected_readouts.size() != 0)
            @(posedge clk);
        // leave room for stray result beats after the queue drains
        repeat (40) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
sv/hslh_pkg.sv
sv/hslh_bank.sv
sv/hslh_mean_div.sv
sv/hsl_histogram_with_mean_core.sv
sv/hslh_checker.sv
tb/tb_hsl_histogram_with_mean_core.sv
